// ----- hw/rtl/md5_digest_engine_macros.svh -----
// ----------------------------------------------------------------------------
// MD5 digest engine assertion macros
// Shared concurrent assertion wrappers for the engine's RTL.
// ----------------------------------------------------------------------------
`ifndef MD5_DIGEST_ENGINE_MACROS_SVH
`define MD5_DIGEST_ENGINE_MACROS_SVH

// Check on every clock edge outside reset.
`define MD5_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check on every clock edge, reset included.
`define MD5_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/md5_pkg.sv -----
// ----------------------------------------------------------------------------
// MD5 digest engine package
// Types, round tables and helper functions shared by the engine modules.
// ----------------------------------------------------------------------------
package md5_pkg;

    localparam int COUNT_W = 61;

    localparam logic [31:0] CHAIN_INIT [4] = '{
        32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
    };

    localparam logic [7:0] PAD_MARK    = 8'h80;
    localparam logic [5:0] LEN_POS     = 6'd56;
    localparam logic [7:0] FLOOR_RESET = 8'd100;
    localparam logic       REG_BRIGHTNESS_FLOOR = 1'b0;

    localparam logic [31:0] MD5_K [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam logic [4:0] MD5_S [16] = '{
        5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_FOLD,
        ST_DONE
    } md5_state_t;

    typedef enum logic [1:0] {
        BLK_DATA,
        BLK_PAD,
        BLK_PAD_LEN,
        BLK_LEN
    } md5_blk_t;

    typedef struct packed {
        logic        init_work;
        logic        round_en;
        logic        fold_en;
        logic        chain_reset;
        logic [5:0]  round_idx;
        logic [3:0]  rd_addr;
        logic        wr_en;
        logic [3:0]  wr_word;
        logic [1:0]  wr_lane;
        md5_blk_t    blk;
        logic [5:0]  pos;
        logic [63:0] bit_len;
    } md5_ctl_t;

    function automatic logic [3:0] md5_g(input logic [5:0] i);
        logic [3:0] n;
        logic [3:0] g;
        n = i[3:0];
        case (i[5:4])
            2'd0:    g = n;
            2'd1:    g = (n * 4'd5) + 4'd1;
            2'd2:    g = (n * 4'd3) + 4'd5;
            default: g = n * 4'd7;
        endcase
        return g;
    endfunction

    function automatic logic [31:0] md5_rotl(input logic [31:0] v, input logic [4:0] s);
        logic [63:0] dbl;
        dbl = {v, v} << s;
        return dbl[63:32];
    endfunction

endpackage

// ----- hw/rtl/md5_msg_buf.sv -----
// ----------------------------------------------------------------------------
// MD5 message buffer
// 16-word block store with byte writes and a registered read port; applies
// the end-of-message padding and length words on the read side.
// ----------------------------------------------------------------------------
module md5_msg_buf
(
    input  logic             clk,
    input  md5_pkg::md5_ctl_t ctl,
    input  logic [7:0]       data_byte,
    output logic [31:0]      word
);
    import md5_pkg::*;

    logic [3:0][7:0] msg_mem [16];
    logic [31:0]     rd_data_reg;
    logic [3:0]      rd_addr_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            msg_mem[ctl.wr_word][ctl.wr_lane] <= data_byte;
        end
        rd_data_reg <= msg_mem[ctl.rd_addr];
        rd_addr_reg <= ctl.rd_addr;
    end

    always_comb
    begin
        logic [5:0] k;
        logic [7:0] b;
        word = '0;
        for (int j = 0; j < 4; j++)
        begin
            k = {rd_addr_reg, 2'(j)};
            case (ctl.blk)
                BLK_DATA:
                    b = rd_data_reg[8*j +: 8];
                BLK_PAD, BLK_PAD_LEN:
                    if (k < ctl.pos)
                        b = rd_data_reg[8*j +: 8];
                    else if (k == ctl.pos)
                        b = PAD_MARK;
                    else
                        b = 8'd0;
                default:
                    b = 8'd0;
            endcase
            word[8*j +: 8] = b;
        end
        if (ctl.blk == BLK_PAD_LEN || ctl.blk == BLK_LEN)
        begin
            if (rd_addr_reg == 4'd14)
                word = ctl.bit_len[31:0];
            else if (rd_addr_reg == 4'd15)
                word = ctl.bit_len[63:32];
        end
    end

endmodule

// ----- hw/rtl/md5_round_unit.sv -----
// ----------------------------------------------------------------------------
// MD5 round unit
// Working registers and chaining words; one compression round per cycle,
// then a fold of the working state into the chain.
// ----------------------------------------------------------------------------
module md5_round_unit
(
    input  logic              clk,
    input  logic              rst_n,
    input  md5_pkg::md5_ctl_t ctl,
    input  logic [31:0]       word,
    output logic [3:0][31:0]  chain
);
    import md5_pkg::*;

    logic [31:0] a_reg, b_reg, c_reg, d_reg;
    logic [31:0] chain_reg [4];
    logic [31:0] f_val;
    logic [31:0] sum_val;
    logic [31:0] b_next;

    always_comb
    begin
        case (ctl.round_idx[5:4])
            2'd0:    f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            2'd1:    f_val = (d_reg & b_reg) | (~d_reg & c_reg);
            2'd2:    f_val = b_reg ^ c_reg ^ d_reg;
            default: f_val = c_reg ^ (b_reg | ~d_reg);
        endcase
        sum_val = a_reg + f_val + MD5_K[ctl.round_idx] + word;
        b_next  = b_reg + md5_rotl(sum_val,
                                   MD5_S[{ctl.round_idx[5:4], ctl.round_idx[1:0]}]);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.init_work)
        begin
            a_reg <= chain_reg[0];
            b_reg <= chain_reg[1];
            c_reg <= chain_reg[2];
            d_reg <= chain_reg[3];
        end
        else if (ctl.round_en)
        begin
            a_reg <= d_reg;
            b_reg <= b_next;
            c_reg <= b_reg;
            d_reg <= c_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
                chain_reg[i] <= CHAIN_INIT[i];
        end
        else if (ctl.chain_reset)
        begin
            for (int i = 0; i < 4; i++)
                chain_reg[i] <= CHAIN_INIT[i];
        end
        else if (ctl.fold_en)
        begin
            chain_reg[0] <= chain_reg[0] + a_reg;
            chain_reg[1] <= chain_reg[1] + b_reg;
            chain_reg[2] <= chain_reg[2] + c_reg;
            chain_reg[3] <= chain_reg[3] + d_reg;
        end
    end

    always_comb
    begin
        for (int i = 0; i < 4; i++)
            chain[i] = chain_reg[i];
    end

endmodule

// ----- hw/rtl/md5_ctrl.sv -----
// ----------------------------------------------------------------------------
// MD5 sequencer
// Accepts message bytes, counts the length and steps the round unit through
// data, padding and length blocks.
// ----------------------------------------------------------------------------
`include "md5_digest_engine_macros.svh"

module md5_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              byte_valid,
    input  logic              last,
    input  logic              res_free,
    output logic              res_load,
    output md5_pkg::md5_ctl_t ctl
);
    import md5_pkg::*;

    md5_state_t           state_reg, state_next;
    md5_blk_t             blk_reg, blk_next;
    logic                 fin_reg, fin_next;
    logic [5:0]           round_reg, round_next;
    logic [COUNT_W-1:0]   cnt_reg, cnt_next;
    logic [COUNT_W-1:0]   cnt_inc;
    logic                 in_acc;
    logic                 blk_full;
    logic [5:0]           pos_after;

    assign in_acc    = in_valid && in_ready;
    assign cnt_inc   = cnt_reg + COUNT_W'(1);
    assign blk_full  = byte_valid && (cnt_inc[5:0] == 6'd0);
    assign pos_after = byte_valid ? cnt_inc[5:0] : cnt_reg[5:0];

    always_comb
    begin
        state_next = state_reg;
        blk_next   = blk_reg;
        fin_next   = fin_reg;
        round_next = round_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:
                if (in_acc)
                begin
                    fin_next = last;
                    if (byte_valid)
                        cnt_next = cnt_inc;
                    if (blk_full)
                    begin
                        blk_next   = BLK_DATA;
                        state_next = ST_LOAD;
                    end
                    else if (last)
                    begin
                        blk_next   = (pos_after >= LEN_POS) ? BLK_PAD : BLK_PAD_LEN;
                        state_next = ST_LOAD;
                    end
                end
            ST_LOAD:
            begin
                round_next = 6'd0;
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                round_next = round_reg + 6'd1;
                if (round_reg == 6'd63)
                    state_next = ST_FOLD;
            end
            ST_FOLD:
                case (blk_reg)
                    BLK_DATA:
                        if (fin_reg)
                        begin
                            blk_next   = (cnt_reg[5:0] >= LEN_POS) ? BLK_PAD : BLK_PAD_LEN;
                            state_next = ST_LOAD;
                        end
                        else
                        begin
                            state_next = ST_IDLE;
                        end
                    BLK_PAD:
                    begin
                        blk_next   = BLK_LEN;
                        state_next = ST_LOAD;
                    end
                    default:
                        state_next = ST_DONE;
                endcase
            ST_DONE:
                if (res_free)
                begin
                    fin_next   = 1'b0;
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready        = (state_reg == ST_IDLE);
        res_load        = (state_reg == ST_DONE) && res_free;
        ctl.init_work   = (state_reg == ST_LOAD);
        ctl.round_en    = (state_reg == ST_ROUND);
        ctl.fold_en     = (state_reg == ST_FOLD);
        ctl.chain_reset = res_load;
        ctl.round_idx   = round_reg;
        case (state_reg)
            ST_LOAD:  ctl.rd_addr = md5_g(6'd0);
            ST_ROUND: ctl.rd_addr = md5_g(round_reg + 6'd1);
            default:  ctl.rd_addr = 4'd0;
        endcase
        ctl.wr_en   = in_acc && byte_valid;
        ctl.wr_word = cnt_reg[5:2];
        ctl.wr_lane = cnt_reg[1:0];
        ctl.blk     = blk_reg;
        ctl.pos     = cnt_reg[5:0];
        ctl.bit_len = {cnt_reg, 3'b000};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            blk_reg   <= BLK_DATA;
            fin_reg   <= 1'b0;
            round_reg <= 6'd0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            blk_reg   <= blk_next;
            fin_reg   <= fin_next;
            round_reg <= round_next;
            cnt_reg   <= cnt_next;
        end
    end

    `MD5_ASSERT(a_load_starts_round0, (state_reg == ST_LOAD) |=> (state_reg == ST_ROUND && round_reg == 6'd0), "round sequence did not start at round 0")
    `MD5_ASSERT(a_last_round_folds, (state_reg == ST_ROUND && round_reg == 6'd63) |=> (state_reg == ST_FOLD), "no fold after the last round")
    `MD5_ASSERT(a_count_holds, (!(in_acc && byte_valid) && !res_load) |=> $stable(cnt_reg), "length count moved without a byte")
    `MD5_ASSERT(a_result_restarts, res_load |=> (cnt_reg == '0 && state_reg == ST_IDLE && !fin_reg), "message state not cleared after result")
    `MD5_ASSERT_ALWAYS(a_reset_idle, (!rst_n) |=> (state_reg == ST_IDLE), "sequencer not idle after reset")

endmodule

// ----- hw/rtl/md5_digest_engine.sv -----
// ----------------------------------------------------------------------------
// MD5 digest engine
// Byte-serial MD5 hash with a brightness-floored color from the digest.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one message byte per item with
//   byte_valid and last. An item with last set finishes the message and
//   produces one result item on the output channel (out_valid/out_ready):
//   the 16-byte digest and a color taken from digest bytes 0..2.
//   A byte that does not complete a 64-byte block leaves the engine idle. A
//   byte that completes one holds in_ready low while the engine loads the
//   working registers, runs the rounds of the shared round unit and folds.
//   The last item then adds one padding block with the length, or a padding
//   block and a length block when the tail leaves 56 or more bytes, before
//   out_valid. The output register lets the next message start while a
//   result waits; a second result stalls the engine until out_ready takes
//   the first. Reset loads the MD5 initial chain, clears the length count
//   and sets brightness_floor to 100. The block buffer needs no clearing.
//   brightness_floor is at APB address 0; the user writes it only while
//   idle, and the engine does not enforce this.
// ----------------------------------------------------------------------------
module md5_digest_engine
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        byte_valid,
    input  logic        last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] digest_low,
    output logic [63:0] digest_high,
    output logic [7:0]  color_red,
    output logic [7:0]  color_green,
    output logic [7:0]  color_blue,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import md5_pkg::*;

    md5_ctl_t         ctl;
    logic [31:0]      word;
    logic [3:0][31:0] chain;
    logic             res_free;
    logic             res_load;
    logic [7:0]       floor_reg;
    logic             out_valid_reg;
    logic [63:0]      digest_low_reg, digest_high_reg;
    logic [7:0]       red_reg, green_reg, blue_reg;
    logic [7:0]       red_next, green_next, blue_next;
    logic [9:0]       rgb_sum;
    logic [9:0]       floor_x3;

    md5_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .byte_valid (byte_valid),
        .last       (last),
        .res_free   (res_free),
        .res_load   (res_load),
        .ctl        (ctl)
    );

    md5_msg_buf u_buf
    (
        .clk       (clk),
        .ctl       (ctl),
        .data_byte (data_byte),
        .word      (word)
    );

    md5_round_unit u_round
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .word  (word),
        .chain (chain)
    );

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_BRIGHTNESS_FLOOR) ? {24'd0, floor_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            floor_reg <= FLOOR_RESET;
        else if (psel && penable && pwrite && pready && paddr[2] == REG_BRIGHTNESS_FLOOR)
            floor_reg <= pwdata[7:0];
    end

    assign res_free = !out_valid_reg || out_ready;

    always_comb
    begin
        rgb_sum    = 10'(chain[0][7:0]) + 10'(chain[0][15:8]) + 10'(chain[0][23:16]);
        floor_x3   = {1'b0, floor_reg, 1'b0} + 10'(floor_reg);
        red_next   = chain[0][7:0];
        green_next = chain[0][15:8];
        blue_next  = chain[0][23:16];
        if (rgb_sum < floor_x3)
        begin
            if (red_next < floor_reg)
                red_next = floor_reg;
            if (green_next < floor_reg)
                green_next = floor_reg;
            if (blue_next < floor_reg)
                blue_next = floor_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (res_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            digest_low_reg  <= {chain[1], chain[0]};
            digest_high_reg <= {chain[3], chain[2]};
            red_reg         <= red_next;
            green_reg       <= green_next;
            blue_reg        <= blue_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign digest_low  = digest_low_reg;
    assign digest_high = digest_high_reg;
    assign color_red   = red_reg;
    assign color_green = green_reg;
    assign color_blue  = blue_reg;

endmodule

// ----- tb/sv/md5_digest_checker.sv -----
// ----------------------------------------------------------------------------
// MD5 digest engine checker
// Watches the APB port and both item channels of the engine. Keeps its own
// copy of the chain, block buffer, length count and brightness floor, works
// out the digest and color of every finished message, and compares each
// result item field by field with the oldest expected digest. Also checks
// read data of the brightness floor register.
// ----------------------------------------------------------------------------
module md5_digest_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        byte_valid,
    input  logic        last,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [63:0] digest_low,
    input  logic [63:0] digest_high,
    input  logic [7:0]  color_red,
    input  logic [7:0]  color_green,
    input  logic [7:0]  color_blue,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic [31:0] prdata,
    input  logic        pready,
    output int          errors,
    output int          pending
);

    localparam logic [2:0]   FLOOR_ADDR = {md5_pkg::REG_BRIGHTNESS_FLOOR, 2'b00};
    localparam logic [127:0] CHAIN_START =
        128'h10325476_98badcfe_efcdab89_67452301;

    localparam logic [31:0] ROUND_ADD [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam int ROT_BY [16] = '{
        7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
    };

    typedef struct packed {
        logic [63:0] lo;
        logic [63:0] hi;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
    } digest_item_t;

    digest_item_t digest_q [$];

    logic [127:0] chain    = CHAIN_START;
    logic [511:0] msg_blk  = '0;
    logic [60:0]  msg_len  = '0;
    logic [7:0]   floor_q  = md5_pkg::FLOOR_RESET;

    assign pending = digest_q.size();

    initial errors = 0;

    function automatic logic [127:0] md5_compress(input logic [127:0] h,
                                                  input logic [511:0] blk);
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
        logic [31:0] f;
        logic [31:0] sum;
        logic [31:0] hold;
        int          g;
        int          s;
        a = h[31:0];
        b = h[63:32];
        c = h[95:64];
        d = h[127:96];
        for (int i = 0; i < 64; i++)
        begin
            case (i / 16)
                0:
                begin
                    f = (b & c) | (~b & d);
                    g = i;
                end
                1:
                begin
                    f = (d & b) | (~d & c);
                    g = (5 * i + 1) % 16;
                end
                2:
                begin
                    f = b ^ c ^ d;
                    g = (3 * i + 5) % 16;
                end
                default:
                begin
                    f = c ^ (b | ~d);
                    g = (7 * i) % 16;
                end
            endcase
            s    = ROT_BY[(i / 16) * 4 + (i % 4)];
            sum  = a + f + ROUND_ADD[i] + blk[32 * g +: 32];
            hold = d;
            d    = c;
            c    = b;
            b    = b + ((sum << s) | (sum >> (32 - s)));
            a    = hold;
        end
        return {h[127:96] + d, h[95:64] + c, h[63:32] + b, h[31:0] + a};
    endfunction

    function automatic logic [7:0] lift(input logic [7:0] v, input logic [7:0] fl);
        return (v < fl) ? fl : v;
    endfunction

    task automatic finish_message();
        int           pos;
        logic [63:0]  bit_len;
        logic [9:0]   shade;
        digest_item_t exp_item;
        pos = int'(msg_len[5:0]);
        msg_blk[8 * pos +: 8] = md5_pkg::PAD_MARK;
        for (int i = pos + 1; i < 64; i++)
            msg_blk[8 * i +: 8] = 8'h00;
        if (pos >= int'(md5_pkg::LEN_POS))
        begin
            chain   = md5_compress(chain, msg_blk);
            msg_blk = '0;
        end
        bit_len = {msg_len, 3'b000};
        msg_blk[511:448] = bit_len;
        chain = md5_compress(chain, msg_blk);

        exp_item.lo    = chain[63:0];
        exp_item.hi    = chain[127:64];
        exp_item.red   = chain[7:0];
        exp_item.green = chain[15:8];
        exp_item.blue  = chain[23:16];
        shade = {2'b00, exp_item.red} + {2'b00, exp_item.green} + {2'b00, exp_item.blue};
        if (shade < 10'(3 * int'(floor_q)))
        begin
            exp_item.red   = lift(exp_item.red, floor_q);
            exp_item.green = lift(exp_item.green, floor_q);
            exp_item.blue  = lift(exp_item.blue, floor_q);
        end
        digest_q = {digest_q, exp_item};

        chain   = CHAIN_START;
        msg_len = '0;
    endtask

    task automatic compare_result();
        digest_item_t exp_item;
        if (digest_q.size() == 0)
        begin
            $error("unexpected result item: digest_low %h digest_high %h",
                   digest_low, digest_high);
            errors++;
        end
        else
        begin
            exp_item = digest_q.pop_front();
            if (digest_low !== exp_item.lo)
            begin
                $error("digest_low expected %h actual %h", exp_item.lo, digest_low);
                errors++;
            end
            if (digest_high !== exp_item.hi)
            begin
                $error("digest_high expected %h actual %h", exp_item.hi, digest_high);
                errors++;
            end
            if (color_red !== exp_item.red)
            begin
                $error("color_red expected %h actual %h", exp_item.red, color_red);
                errors++;
            end
            if (color_green !== exp_item.green)
            begin
                $error("color_green expected %h actual %h", exp_item.green, color_green);
                errors++;
            end
            if (color_blue !== exp_item.blue)
            begin
                $error("color_blue expected %h actual %h", exp_item.blue, color_blue);
                errors++;
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            chain   = CHAIN_START;
            msg_len = '0;
            floor_q = md5_pkg::FLOOR_RESET;
            digest_q.delete();
        end
        else
        begin
            if (psel && penable && pready && paddr == FLOOR_ADDR)
            begin
                if (pwrite)
                    floor_q = pwdata[7:0];
                else if (prdata !== {24'h000000, floor_q})
                begin
                    $error("prdata expected %h actual %h", {24'h000000, floor_q}, prdata);
                    errors++;
                end
            end

            if (out_valid && out_ready)
                compare_result();

            if (in_valid && in_ready)
            begin
                if (byte_valid)
                begin
                    msg_blk[8 * int'(msg_len[5:0]) +: 8] = data_byte;
                    msg_len = msg_len + 61'd1;
                    if (msg_len[5:0] == 6'd0)
                        chain = md5_compress(chain, msg_blk);
                end
                if (last)
                    finish_message();
            end
        end
    end

endmodule

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// MD5 digest engine testbench
// Drives byte messages of many lengths into the engine, around the padding
// and block boundaries, with idle items, empty messages and data plus end
// items. Steps the brightness floor through its extremes over several
// phases and stalls both channels at random. The checker beside the engine
// predicts and compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;

    localparam logic [2:0] FLOOR_ADDR    = {md5_pkg::REG_BRIGHTNESS_FLOOR, 2'b00};
    localparam logic [2:0] UNMAPPED_ADDR = 3'd4;
    localparam int         CYCLE_LIMIT   = 2000000;
    localparam int         SETTLE_CYCLES = 150;
    localparam int         PHASES        = 10;
    localparam int         PHASE_ITEMS   = 170;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        in_valid    = 1'b0;
    logic        in_ready;
    logic [7:0]  data_byte   = 8'h00;
    logic        byte_valid  = 1'b0;
    logic        last        = 1'b0;
    logic        out_valid;
    logic        out_ready   = 1'b0;
    logic [63:0] digest_low;
    logic [63:0] digest_high;
    logic [7:0]  color_red;
    logic [7:0]  color_green;
    logic [7:0]  color_blue;
    logic        psel        = 1'b0;
    logic        penable     = 1'b0;
    logic        pwrite      = 1'b0;
    logic [2:0]  paddr       = 3'd0;
    logic [31:0] pwdata      = 32'h0;
    logic [31:0] prdata;
    logic        pready;

    int errors;
    int pending;
    int items_sent  = 0;
    int cycle_count = 0;
    int stall_left  = 0;
    bit no_idle     = 1'b0;

    md5_digest_engine dut (.*);

    md5_digest_checker checker_i (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 40);
    endfunction

    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 8'h00;
        else if (r == 1)
            return 8'hFF;
        else
            return 8'($urandom_range(0, 255));
    endfunction

    // hold ready low for a random stretch now and then
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            out_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
                stall_left <= pick_gap();
        end
    end

    task automatic push_item(input logic [7:0] d, input logic bv, input logic lst);
        int n;
        n = pick_gap();
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(negedge clk);
        end
        in_valid   <= 1'b1;
        data_byte  <= d;
        byte_valid <= bv;
        last       <= lst;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
        if (bv || lst)
            items_sent++;
    endtask

    task automatic wait_results();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic apb_access(input logic wr, input logic [2:0] addr,
                              input logic [31:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic send_message(input int len);
        bit end_on_data;
        end_on_data = (len > 0) && ($urandom_range(0, 1) == 1);
        for (int k = 0; k < len; k++)
        begin
            if ($urandom_range(0, 99) < 8)
                push_item(pick_byte(), 1'b0, 1'b0);
            push_item(pick_byte(), 1'b1, end_on_data && (k == len - 1));
        end
        if (!end_on_data)
            push_item(pick_byte(), 1'b0, 1'b1);
    endtask

    function automatic int pick_length();
        int edges [12] = '{55, 56, 57, 63, 64, 65, 119, 120, 121, 127, 128, 129};
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return $urandom_range(0, 6);
        else if (r < 70)
            return $urandom_range(7, 40);
        else if (r < 85)
            return edges[$urandom_range(0, 11)];
        else
            return $urandom_range(41, 140);
    endfunction

    initial
    begin
        logic [7:0] fl;
        int         msgs;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset floor, empty message, idle item, single bytes, "abc"
        push_item(8'h00, 1'b0, 1'b1);
        push_item(8'hA5, 1'b0, 1'b0);
        push_item(8'h00, 1'b1, 1'b1);
        push_item(8'hFF, 1'b1, 1'b1);
        push_item(8'h61, 1'b1, 1'b0);
        push_item(8'h62, 1'b1, 1'b0);
        push_item(8'h63, 1'b1, 1'b1);
        push_item(8'h5A, 1'b1, 1'b0);
        push_item(8'h3C, 1'b0, 1'b0);
        push_item(8'hC3, 1'b0, 1'b1);
        push_item(8'h7E, 1'b0, 1'b1);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            wait_results();
            repeat (SETTLE_CYCLES) @(negedge clk);
            case (phase)
                0:       fl = 8'd255;
                1:       fl = 8'd0;
                2:       fl = 8'd100;
                3:       fl = 8'd1;
                4:       fl = 8'd254;
                default: fl = 8'($urandom_range(0, 255));
            endcase
            apb_access(1'b1, FLOOR_ADDR, {24'($urandom()), fl});
            if (phase == 3)
                apb_access(1'b1, UNMAPPED_ADDR, $urandom());
            apb_access(1'b0, FLOOR_ADDR, 32'h0);
            no_idle = (phase == 5);
            msgs = 0;
            while (items_sent < PHASE_ITEMS * (phase + 1))
            begin
                send_message(pick_length());
                msgs++;
                // drain the result path mid-phase
                if (phase == 2 && msgs == 3)
                    wait_results();
            end
        end

        wait_results();
        repeat (200) @(negedge clk);
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
